// ===== rtl/tmwe_pkg.sv =====
// Package for the trimmed mean and standard error block.
// Holds sizes, the shared arithmetic unit's operation codes and helpers.
// No dependencies.
package tmwe_pkg;

   localparam int SAMPLE_W    = 24;
   localparam int MAX_SAMPLES = 1024;
   localparam int IDX_W       = $clog2(MAX_SAMPLES);
   localparam int CNT_W       = IDX_W + 1;
   localparam int ADDR_W      = IDX_W + 1;
   localparam int STORE_DEPTH = 2 * MAX_SAMPLES;
   localparam int SUM_W       = SAMPLE_W + IDX_W;
   localparam int SQ_W        = 2 * SAMPLE_W + IDX_W;
   localparam int FRAC_W      = 16;
   localparam int RES_W       = 32;
   localparam int ALU_W       = 96;
   localparam int ALU_CNT_W   = $clog2(ALU_W + 1);

   localparam logic [FRAC_W:0] TRIM_LIMIT = 17'd64881;

   // Configuration register indexes.
   localparam logic CSR_TRIM_LOW  = 1'b0;
   localparam logic CSR_TRIM_HIGH = 1'b1;

   typedef enum logic [1:0] {
      ALU_MUL  = 2'd0,
      ALU_DIV  = 2'd1,
      ALU_SQRT = 2'd2
   } alu_op_type;

   typedef struct packed {
      logic       start;
      alu_op_type op;
   } alu_req_type;

   // Clamp a wide unsigned value to the 32-bit result range.
   function automatic logic [RES_W-1:0] sat32(input logic [ALU_W-1:0] v);
      logic [RES_W-1:0] r;
      r = (|v[ALU_W-1:RES_W]) ? {RES_W{1'b1}} : v[RES_W-1:0];
      return r;
   endfunction

endpackage

// ===== rtl/tmwe_ram.sv =====
// Generic single-write, single-read memory with registered read data.
// No dependencies.
module tmwe_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   // Write port and registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== rtl/tmwe_alu.sv =====
// Shared bit-serial arithmetic unit: multiply, divide and square root.
// Depends on tmwe_pkg.
module tmwe_alu (
   input  logic                        clock,
   input  logic                        reset,
   input  tmwe_pkg::alu_req_type       req,
   input  logic [tmwe_pkg::ALU_W-1:0]  opa,
   input  logic [tmwe_pkg::ALU_W-1:0]  opb,
   output logic                        done,
   output logic [tmwe_pkg::ALU_W-1:0]  result
);

   localparam int W = tmwe_pkg::ALU_W;

   logic                                busy_ff, busy_in;
   logic                                done_ff, done_in;
   logic [tmwe_pkg::ALU_CNT_W-1:0]      cnt_ff, cnt_in;
   tmwe_pkg::alu_op_type                op_ff, op_in;
   logic [W-1:0]                        acc_ff, acc_in;
   logic [W-1:0]                        x_ff, x_in;
   logic [W-1:0]                        y_ff, y_in;
   logic [W-1:0]                        remt;
   logic [W-1:0]                        trial;

   // One step of the selected operation per cycle.
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      op_in   = op_ff;
      acc_in  = acc_ff;
      x_in    = x_ff;
      y_in    = y_ff;
      remt    = '0;
      trial   = '0;
      if (req.start) begin
         busy_in = 1'b1;
         op_in   = req.op;
         acc_in  = '0;
         x_in    = opa;
         y_in    = (req.op == tmwe_pkg::ALU_SQRT) ? '0 : opb;
         cnt_in  = (req.op == tmwe_pkg::ALU_SQRT) ? tmwe_pkg::ALU_CNT_W'(W / 2)
                                                  : tmwe_pkg::ALU_CNT_W'(W);
      end else if (busy_ff) begin
         unique case (op_ff)
            tmwe_pkg::ALU_MUL: begin
               if (y_ff[0]) begin
                  acc_in = acc_ff + x_ff;
               end
               x_in = {x_ff[W-2:0], 1'b0};
               y_in = {1'b0, y_ff[W-1:1]};
            end
            tmwe_pkg::ALU_DIV: begin
               remt = {acc_ff[W-2:0], x_ff[W-1]};
               if (remt >= y_ff) begin
                  acc_in = remt - y_ff;
                  x_in   = {x_ff[W-2:0], 1'b1};
               end else begin
                  acc_in = remt;
                  x_in   = {x_ff[W-2:0], 1'b0};
               end
            end
            tmwe_pkg::ALU_SQRT: begin
               remt  = {acc_ff[W-3:0], x_ff[W-1:W-2]};
               trial = {y_ff[W-3:0], 2'b01};
               x_in  = {x_ff[W-3:0], 2'b00};
               if (remt >= trial) begin
                  acc_in = remt - trial;
                  y_in   = {y_ff[W-2:0], 1'b1};
               end else begin
                  acc_in = remt;
                  y_in   = {y_ff[W-2:0], 1'b0};
               end
            end
            default: begin
               acc_in = acc_ff;
            end
         endcase
         cnt_in = cnt_ff - 1'b1;
         if (cnt_ff == tmwe_pkg::ALU_CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      op_ff  <= op_in;
      acc_ff <= acc_in;
      x_ff   <= x_in;
      y_ff   <= y_in;
   end

   // Result selection by operation.
   always_comb begin
      case (op_ff)
         tmwe_pkg::ALU_MUL:  result = acc_ff;
         tmwe_pkg::ALU_DIV:  result = x_ff;
         tmwe_pkg::ALU_SQRT: result = y_ff;
         default:            result = acc_ff;
      endcase
   end

   assign done = done_ff;

endmodule

// ===== rtl/truncated_mean_with_error.sv =====
// Top level of the trimmed mean and standard error block.
// Depends on tmwe_pkg, tmwe_ram and tmwe_alu.
//
// Samples are taken one per cycle while busy is low and are stored in one of two
// views of a 2048-entry memory (1024 per view; later samples set the overflow flag).
// A sample with req_last_sample high makes the block busy while it ranks every
// stored sample of that view against all others through the single memory read
// port, then squares each kept sample on the shared bit-serial unit and finishes
// with one divide on that unit and, when more than one sample is kept, four
// multiplies, a divide and a square root. The result is shown for one cycle with
// rsp_valid and cannot be stalled; the view is then emptied and busy drops. Trim
// fractions may be written whenever the block idles.
module truncated_mean_with_error (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          start,
   output logic                          busy,
   input  logic                          req_view_select,
   input  logic [tmwe_pkg::SAMPLE_W-1:0] req_sample_value,
   input  logic                          req_last_sample,
   output logic                          rsp_valid,
   output logic                          rsp_result_view,
   output logic [31:0]                   rsp_trimmed_mean,
   output logic [31:0]                   rsp_standard_error,
   output logic [10:0]                   rsp_kept_count,
   output logic                          rsp_single_sample,
   output logic                          rsp_store_overflow,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic                          csr_index,
   input  logic [15:0]                   csr_data
);

   localparam int CW = tmwe_pkg::CNT_W;
   localparam int IW = tmwe_pkg::IDX_W;
   localparam int AW = tmwe_pkg::ALU_W;
   localparam int SW = tmwe_pkg::SAMPLE_W;

   typedef enum logic [12:0] {
      S_IDLE   = 13'b0000000000001,
      S_TRIM   = 13'b0000000000010,
      S_FETCH  = 13'b0000000000100,
      S_LATCH  = 13'b0000000001000,
      S_SCAN   = 13'b0000000010000,
      S_DECIDE = 13'b0000000100000,
      S_SQ     = 13'b0000001000000,
      S_MEAN   = 13'b0000010000000,
      S_T1     = 13'b0000100000000,
      S_T2     = 13'b0001000000000,
      S_DEN    = 13'b0010000000000,
      S_DIV    = 13'b0100000000000,
      S_OUT    = 13'b1000000000000
   } state_type;

   state_type                      state_ff, state_in;
   logic [tmwe_pkg::FRAC_W-1:0]    tlow_ff, tlow_in;
   logic [tmwe_pkg::FRAC_W-1:0]    thigh_ff, thigh_in;
   logic [CW-1:0]                  count_ff [2];
   logic [CW-1:0]                  count_in [2];
   logic [1:0]                     ovf_ff, ovf_in;
   logic                           v_ff, v_in;
   logic [CW-1:0]                  n_ff, n_in;
   logic [CW-1:0]                  nlow_ff, nlow_in;
   logic [CW-1:0]                  end_ff, end_in;
   logic [CW-1:0]                  m_ff, m_in;
   logic [CW-1:0]                  i_ff, i_in;
   logic [CW-1:0]                  j_ff, j_in;
   logic [CW-1:0]                  jd_ff, jd_in;
   logic [CW-1:0]                  rank_ff, rank_in;
   logic                           vld_ff, vld_in;
   logic                           go_ff, go_in;
   logic                           sqr_ff, sqr_in;
   logic [SW-1:0]                  xi_ff, xi_in;
   logic [tmwe_pkg::SUM_W-1:0]     sum_ff, sum_in;
   logic [tmwe_pkg::SQ_W-1:0]      sumsq_ff, sumsq_in;
   logic [31:0]                    mean_ff, mean_in;
   logic [31:0]                    err_ff, err_in;
   logic [AW-1:0]                  tmp_ff, tmp_in;
   logic [AW-1:0]                  den_ff, den_in;

   logic                           accept;
   logic                           wr_en;
   logic [tmwe_pkg::ADDR_W-1:0]    wr_addr;
   logic [tmwe_pkg::ADDR_W-1:0]    rd_addr;
   logic [SW-1:0]                  rd_data;
   tmwe_pkg::alu_req_type          alu_req;
   logic [AW-1:0]                  alu_a, alu_b;
   logic                           alu_done;
   logic [AW-1:0]                  alu_res;
   logic [CW+tmwe_pkg::FRAC_W-1:0] prod_low, prod_high;
   logic [CW-1:0]                  t_low, t_high, t_end;
   logic [CW-1:0]                  i_next;

   assign accept    = start && (state_ff == S_IDLE);
   assign busy      = (state_ff != S_IDLE);
   assign csr_ready = 1'b1;
   assign wr_en     = accept && (count_ff[req_view_select] < CW'(tmwe_pkg::MAX_SAMPLES));
   assign wr_addr   = {req_view_select, count_ff[req_view_select][IW-1:0]};
   assign i_next    = i_ff + 1'b1;

   tmwe_ram #(
      .WIDTH (SW),
      .DEPTH (tmwe_pkg::STORE_DEPTH)
   ) u_store (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (wr_addr),
      .wr_data (req_sample_value),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   tmwe_alu u_alu (
      .clock  (clock),
      .reset  (reset),
      .req    (alu_req),
      .opa    (alu_a),
      .opb    (alu_b),
      .done   (alu_done),
      .result (alu_res)
   );

   // Trim counts from the fractions and the sample count.
   always_comb begin
      prod_low  = (CW + tmwe_pkg::FRAC_W)'(tlow_ff) * (CW + tmwe_pkg::FRAC_W)'(n_ff);
      prod_high = (CW + tmwe_pkg::FRAC_W)'(thigh_ff) * (CW + tmwe_pkg::FRAC_W)'(n_ff);
      t_low     = prod_low[CW+tmwe_pkg::FRAC_W-1:tmwe_pkg::FRAC_W];
      t_high    = prod_high[CW+tmwe_pkg::FRAC_W-1:tmwe_pkg::FRAC_W];
      if (({1'b0, tlow_ff} + {1'b0, thigh_ff}) >= tmwe_pkg::TRIM_LIMIT) begin
         t_low  = '0;
         t_high = '0;
      end
      if (t_low >= n_ff) begin
         t_low = '0;
      end
      if (t_high >= n_ff) begin
         t_high = '0;
      end
      t_end = n_ff - t_high;
      if (t_end <= t_low) begin
         t_low = '0;
         t_end = n_ff;
      end
   end

   // Sequencer and datapath next values.
   always_comb begin
      state_in = state_ff;
      tlow_in  = tlow_ff;
      thigh_in = thigh_ff;
      count_in = count_ff;
      ovf_in   = ovf_ff;
      v_in     = v_ff;
      n_in     = n_ff;
      nlow_in  = nlow_ff;
      end_in   = end_ff;
      m_in     = m_ff;
      i_in     = i_ff;
      j_in     = j_ff;
      jd_in    = jd_ff;
      rank_in  = rank_ff;
      vld_in   = 1'b0;
      go_in    = go_ff;
      sqr_in   = sqr_ff;
      xi_in    = xi_ff;
      sum_in   = sum_ff;
      sumsq_in = sumsq_ff;
      mean_in  = mean_ff;
      err_in   = err_ff;
      tmp_in   = tmp_ff;
      den_in   = den_ff;
      rd_addr  = '0;
      alu_req.start = 1'b0;
      alu_req.op    = tmwe_pkg::ALU_MUL;
      alu_a    = '0;
      alu_b    = '0;

      // Configuration writes.
      if (csr_valid) begin
         unique case (csr_index)
            tmwe_pkg::CSR_TRIM_LOW:  tlow_in  = csr_data;
            tmwe_pkg::CSR_TRIM_HIGH: thigh_in = csr_data;
            default:                 tlow_in  = tlow_ff;
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               if (wr_en) begin
                  count_in[req_view_select] = count_ff[req_view_select] + 1'b1;
                  n_in = count_ff[req_view_select] + 1'b1;
               end else begin
                  ovf_in[req_view_select] = 1'b1;
                  n_in = count_ff[req_view_select];
               end
               v_in = req_view_select;
               if (req_last_sample) begin
                  state_in = S_TRIM;
               end
            end
         end
         S_TRIM: begin
            nlow_in  = t_low;
            end_in   = t_end;
            m_in     = t_end - t_low;
            i_in     = '0;
            sum_in   = '0;
            sumsq_in = '0;
            state_in = S_FETCH;
         end
         S_FETCH: begin
            rd_addr  = {v_ff, i_ff[IW-1:0]};
            state_in = S_LATCH;
         end
         S_LATCH: begin
            xi_in    = rd_data;
            j_in     = '0;
            rank_in  = '0;
            state_in = S_SCAN;
         end
         S_SCAN: begin
            // Read sample j while comparing the one read in the previous cycle.
            if (j_ff < n_ff) begin
               rd_addr = {v_ff, j_ff[IW-1:0]};
               vld_in  = 1'b1;
               jd_in   = j_ff;
               j_in    = j_ff + 1'b1;
            end
            if (vld_ff && ((rd_data < xi_ff) || ((rd_data == xi_ff) && (jd_ff < i_ff)))) begin
               rank_in = rank_ff + 1'b1;
            end
            if ((j_ff == n_ff) && !vld_ff) begin
               state_in = S_DECIDE;
            end
         end
         S_DECIDE: begin
            if ((rank_ff >= nlow_ff) && (rank_ff < end_ff)) begin
               sum_in   = sum_ff + tmwe_pkg::SUM_W'(xi_ff);
               state_in = S_SQ;
            end else begin
               i_in     = i_next;
               state_in = (i_next == n_ff) ? S_MEAN : S_FETCH;
            end
         end
         S_SQ: begin
            alu_req.op = tmwe_pkg::ALU_MUL;
            alu_a      = AW'(xi_ff);
            alu_b      = AW'(xi_ff);
            if (alu_done) begin
               sumsq_in = sumsq_ff + alu_res[tmwe_pkg::SQ_W-1:0];
               i_in     = i_next;
               state_in = (i_next == n_ff) ? S_MEAN : S_FETCH;
            end
         end
         S_MEAN: begin
            alu_req.op = tmwe_pkg::ALU_DIV;
            alu_a      = AW'({sum_ff, 8'd0});
            alu_b      = AW'(m_ff);
            if (alu_done) begin
               mean_in  = tmwe_pkg::sat32(alu_res);
               err_in   = '0;
               state_in = (m_ff == CW'(1)) ? S_OUT : S_T1;
            end
         end
         S_T1: begin
            // First pass: sumsq * m. Second pass: m * m.
            alu_req.op = tmwe_pkg::ALU_MUL;
            alu_a      = sqr_ff ? AW'(m_ff) : AW'(sumsq_ff);
            alu_b      = AW'(m_ff);
            if (alu_done) begin
               if (sqr_ff) begin
                  den_in   = alu_res;
                  sqr_in   = 1'b0;
                  state_in = S_DEN;
               end else begin
                  tmp_in   = alu_res;
                  state_in = S_T2;
               end
            end
         end
         S_T2: begin
            alu_req.op = tmwe_pkg::ALU_MUL;
            alu_a      = AW'(sum_ff);
            alu_b      = AW'(sum_ff);
            if (alu_done) begin
               tmp_in   = {tmp_ff[AW-17:0] - alu_res[AW-17:0], 16'd0};
               sqr_in   = 1'b1;
               state_in = S_T1;
            end
         end
         S_DEN: begin
            alu_req.op = tmwe_pkg::ALU_MUL;
            alu_a      = den_ff;
            alu_b      = AW'(m_ff - 1'b1);
            if (alu_done) begin
               den_in   = alu_res;
               state_in = S_DIV;
            end
         end
         S_DIV: begin
            // Divide, then take the square root of the quotient.
            alu_req.op = sqr_ff ? tmwe_pkg::ALU_SQRT : tmwe_pkg::ALU_DIV;
            alu_a      = tmp_ff;
            alu_b      = den_ff;
            if (alu_done) begin
               if (sqr_ff) begin
                  err_in   = tmwe_pkg::sat32(alu_res);
                  sqr_in   = 1'b0;
                  state_in = S_OUT;
               end else begin
                  tmp_in   = alu_res;
                  sqr_in   = 1'b1;
               end
            end
         end
         S_OUT: begin
            count_in[v_ff] = '0;
            ovf_in[v_ff]   = 1'b0;
            state_in       = S_IDLE;
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase

      // Start the shared unit once on entry to each arithmetic step.
      if ((state_ff == S_SQ) || (state_ff == S_MEAN) || (state_ff == S_T1) ||
          (state_ff == S_T2) || (state_ff == S_DEN) || (state_ff == S_DIV)) begin
         if (!go_ff) begin
            alu_req.start = 1'b1;
            go_in = 1'b1;
         end else if (alu_done) begin
            go_in = 1'b0;
         end
      end
   end

   // Control registers.
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= S_IDLE;
         tlow_ff     <= 16'd3277;
         thigh_ff    <= 16'd16384;
         count_ff[0] <= '0;
         count_ff[1] <= '0;
         ovf_ff      <= '0;
         vld_ff      <= 1'b0;
         go_ff       <= 1'b0;
         sqr_ff      <= 1'b0;
      end else begin
         state_ff <= state_in;
         tlow_ff  <= tlow_in;
         thigh_ff <= thigh_in;
         count_ff <= count_in;
         ovf_ff   <= ovf_in;
         vld_ff   <= vld_in;
         go_ff    <= go_in;
         sqr_ff   <= sqr_in;
      end
   end

   // Datapath registers.
   always_ff @(posedge clock) begin
      v_ff     <= v_in;
      n_ff     <= n_in;
      nlow_ff  <= nlow_in;
      end_ff   <= end_in;
      m_ff     <= m_in;
      i_ff     <= i_in;
      j_ff     <= j_in;
      jd_ff    <= jd_in;
      rank_ff  <= rank_in;
      xi_ff    <= xi_in;
      sum_ff   <= sum_in;
      sumsq_ff <= sumsq_in;
      mean_ff  <= mean_in;
      err_ff   <= err_in;
      tmp_ff   <= tmp_in;
      den_ff   <= den_in;
   end

   // Result beat.
   assign rsp_valid          = (state_ff == S_OUT);
   assign rsp_result_view    = v_ff;
   assign rsp_trimmed_mean   = mean_ff;
   assign rsp_standard_error = err_ff;
   assign rsp_kept_count     = m_ff;
   assign rsp_single_sample  = (m_ff == CW'(1));
   assign rsp_store_overflow = ovf_ff[v_ff];

   // The result beat always returns the block to idle.
   assert property (@(posedge clock) disable iff (reset) rsp_valid |=> !busy)
      else $error("block did not return to idle after a result beat");

   // At least one sample is always kept.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_kept_count != 11'd0))
      else $error("result beat with no kept samples");

   // A sample that is not the last one never makes the block busy.
   assert property (@(posedge clock) disable iff (reset)
      (start && !busy && !req_last_sample) |=> !busy)
      else $error("block went busy on a non-final sample");

   // The error is zero whenever a single sample is kept.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_single_sample) |-> (rsp_standard_error == 32'd0))
      else $error("nonzero error with a single kept sample");

endmodule

// ===== test/testbench.sv =====
// Self-checking testbench for truncated_mean_with_error.
// Uses tmwe_pkg and the RTL only; it predicts every result from its own view model.
`timescale 1ns / 1ps

module testbench;

   localparam int VIEW_CAP = 1024;
   localparam logic [16:0] SUM_LIMIT = 17'd64881;

   typedef struct {
      logic        view;
      logic [23:0] value;
      logic        last;
   } sample_beat_type;

   typedef struct {
      logic        view;
      logic [31:0] mean;
      logic [31:0] error;
      logic [10:0] kept;
      logic        single;
      logic        overflow;
   } stats_type;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        start = 1'b0;
   logic        busy;
   logic        req_view_select = 1'b0;
   logic [23:0] req_sample_value = '0;
   logic        req_last_sample = 1'b0;
   logic        rsp_valid;
   logic        rsp_result_view;
   logic [31:0] rsp_trimmed_mean;
   logic [31:0] rsp_standard_error;
   logic [10:0] rsp_kept_count;
   logic        rsp_single_sample;
   logic        rsp_store_overflow;
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic        csr_index = tmwe_pkg::CSR_TRIM_LOW;
   logic [15:0] csr_data = '0;

   // Model state: per-view sample lists, counts, overflow flags and trim fractions.
   logic [23:0] view_samples [2][VIEW_CAP];
   int unsigned view_fill [2];
   logic        view_dropped [2];
   logic [15:0] low_frac;
   logic [15:0] high_frac;
   logic [23:0] sorted_buf [VIEW_CAP];

   sample_beat_type pending_samples[$];
   stats_type       expected_stats[$];
   int              error_count = 0;
   int              gap_left = 0;
   bit              beat_taken = 1'b0;
   bit              gapless = 1'b0;

   truncated_mean_with_error i_dut (
      .clock              (clock),
      .reset              (reset),
      .start              (start),
      .busy               (busy),
      .req_view_select    (req_view_select),
      .req_sample_value   (req_sample_value),
      .req_last_sample    (req_last_sample),
      .rsp_valid          (rsp_valid),
      .rsp_result_view    (rsp_result_view),
      .rsp_trimmed_mean   (rsp_trimmed_mean),
      .rsp_standard_error (rsp_standard_error),
      .rsp_kept_count     (rsp_kept_count),
      .rsp_single_sample  (rsp_single_sample),
      .rsp_store_overflow (rsp_store_overflow),
      .csr_valid          (csr_valid),
      .csr_ready          (csr_ready),
      .csr_index          (csr_index),
      .csr_data           (csr_data)
   );

   // Clock with a 12 ns period.
   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   // Integer square root, truncated.
   function automatic logic [63:0] isqrt(input logic [127:0] x);
      logic [63:0]  y;
      logic [63:0]  c;
      logic [127:0] cw;
      y = '0;
      for (int b = 63; b >= 0; b--) begin
         c = y | (64'd1 << b);
         cw = {64'd0, c} * {64'd0, c};
         if (cw <= x) y = c;
      end
      return y;
   endfunction

   // Store one sample; on the last one of a set, trim, average and queue the stats.
   function automatic void absorb_sample(input logic v, input logic [23:0] x,
                                         input logic last);
      int unsigned  n, nlow, ncut, stop, m, j;
      logic [23:0]  t;
      logic [63:0]  sum;
      logic [127:0] sumsq, dev, den;
      logic [63:0]  mean, err;
      stats_type    s;
      if (view_fill[v] < VIEW_CAP) begin
         view_samples[v][view_fill[v]] = x;
         view_fill[v]++;
      end else begin
         view_dropped[v] = 1'b1;
      end
      if (!last) return;
      n = view_fill[v];
      for (int i = 0; i < n; i++) begin
         t = view_samples[v][i];
         j = i;
         while (j > 0 && sorted_buf[j-1] > t) begin
            sorted_buf[j] = sorted_buf[j-1];
            j--;
         end
         sorted_buf[j] = t;
      end
      nlow = (low_frac * n) >> 16;
      ncut = (high_frac * n) >> 16;
      if ({1'b0, low_frac} + {1'b0, high_frac} >= SUM_LIMIT) begin
         nlow = 0;
         ncut = 0;
      end
      if (nlow >= n) nlow = 0;
      if (ncut >= n) ncut = 0;
      stop = n - ncut;
      if (stop <= nlow) begin
         nlow = 0;
         stop = n;
      end
      m = stop - nlow;
      sum = '0;
      sumsq = '0;
      for (int i = nlow; i < stop; i++) begin
         sum += sorted_buf[i];
         sumsq += {104'd0, sorted_buf[i]} * {104'd0, sorted_buf[i]};
      end
      mean = (sum << 8) / m;
      err = '0;
      if (m > 1) begin
         dev = (sumsq * m - {64'd0, sum} * {64'd0, sum}) << 16;
         den = 128'(m) * m * (m - 1);
         err = isqrt(dev / den);
      end
      s.view = v;
      s.mean = (mean > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : mean[31:0];
      s.error = (err > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : err[31:0];
      s.kept = m[10:0];
      s.single = (m == 1);
      s.overflow = view_dropped[v];
      expected_stats.insert(expected_stats.size(), s);
      view_fill[v] = 0;
      view_dropped[v] = 1'b0;
   endfunction

   function automatic int unsigned pick_gap();
      int unsigned r;
      r = $urandom_range(0, 9);
      if (gapless || r < 6) return 0;
      if (r < 9) return $urandom_range(1, 3);
      return $urandom_range(10, 40);
   endfunction

   function automatic logic [23:0] pick_value();
      case ($urandom_range(0, 9))
         0: return 24'd0;
         1: return 24'hFF_FFFF;
         2: return 24'($urandom_range(0, 15));
         3: return 24'h80_0000 | 24'($urandom_range(0, 3));
         default: return 24'($urandom);
      endcase
   endfunction

   function automatic void queue_sample(input logic v, input logic [23:0] x,
                                        input logic last);
      sample_beat_type b;
      b.view = v;
      b.value = x;
      b.last = last;
      pending_samples.insert(pending_samples.size(), b);
   endfunction

   // Input beat acceptance: predict at the edge where start meets an idle block.
   always @(posedge clock) begin
      if (!reset && start && !busy) begin
         absorb_sample(req_view_select, req_sample_value, req_last_sample);
         beat_taken = 1'b1;
      end
   end

   // Driver: presents the next pending sample on the falling edge, with random gaps.
   always @(negedge clock) begin
      if (!reset && (!start || beat_taken)) begin
         if (beat_taken) gap_left = pick_gap();
         beat_taken = 1'b0;
         if (gap_left > 0) begin
            gap_left--;
            start <= 1'b0;
         end else if (pending_samples.size() > 0) begin
            req_view_select <= pending_samples[0].view;
            req_sample_value <= pending_samples[0].value;
            req_last_sample <= pending_samples[0].last;
            void'(pending_samples.pop_front());
            start <= 1'b1;
         end else begin
            start <= 1'b0;
         end
      end
   end

   task automatic check_field(input string name, input logic [31:0] exp_v,
                              input logic [31:0] act_v);
      if (exp_v !== act_v) begin
         $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, exp_v, act_v);
         error_count++;
      end
   endtask

   // Monitor: every result beat is compared with the oldest expected stats.
   always @(posedge clock) begin
      stats_type s;
      if (!reset && rsp_valid) begin
         if (expected_stats.size() == 0) begin
            $display("%0t: unexpected result, expected none, actual view %0d mean %0d",
                     $time, rsp_result_view, rsp_trimmed_mean);
            error_count++;
         end else begin
            s = expected_stats.pop_front();
            check_field("result_view", s.view, rsp_result_view);
            check_field("trimmed_mean", s.mean, rsp_trimmed_mean);
            check_field("standard_error", s.error, rsp_standard_error);
            check_field("kept_count", s.kept, rsp_kept_count);
            check_field("single_sample", s.single, rsp_single_sample);
            check_field("store_overflow", s.overflow, rsp_store_overflow);
         end
      end
   end

   // Register write on the CSR channel; the model takes it at the accepting edge.
   task automatic write_csr(input logic idx, input logic [15:0] value);
      @(negedge clock);
      csr_index <= idx;
      csr_data <= value;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      if (idx == tmwe_pkg::CSR_TRIM_LOW) low_frac = value;
      else high_frac = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   // Both trim fractions, low first.
   task automatic set_trim(input logic [15:0] low_value, input logic [15:0] high_value);
      write_csr(tmwe_pkg::CSR_TRIM_LOW, low_value);
      write_csr(tmwe_pkg::CSR_TRIM_HIGH, high_value);
   endtask

   task automatic wait_idle();
      do @(posedge clock);
      while (pending_samples.size() > 0 || start || expected_stats.size() > 0);
      repeat (40) @(posedge clock);
   endtask

   // Stimulus: directed sets, then random phases over several trim settings.
   initial begin
      int unsigned count;
      int unsigned size;
      logic        v;
      low_frac = 16'd3277;
      high_frac = 16'd16384;
      view_fill[0] = 0;
      view_fill[1] = 0;
      view_dropped[0] = 1'b0;
      view_dropped[1] = 1'b0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: single sample, extremes, equal values, trimming with reset fractions.
      queue_sample(1'b0, 24'hFF_FFFF, 1'b1);
      queue_sample(1'b1, 24'd0, 1'b0);
      queue_sample(1'b1, 24'hFF_FFFF, 1'b1);
      for (int i = 0; i < 5; i++) queue_sample(1'b0, 24'hFF_FFFF, i == 4);
      for (int i = 0; i < 12; i++) queue_sample(1'b1, pick_value(), i == 11);
      queue_sample(1'b0, 24'd0, 1'b1);
      wait_idle();

      for (int p = 0; p < 9; p++) begin
         // Trim settings: zero, both full, sums at and near the limit, one side only, then random.
         case (p)
            0: set_trim(16'd0, 16'd0);
            1: set_trim(16'hFFFF, 16'hFFFF);
            2: set_trim(16'd32440, 16'd32441);
            3: set_trim(16'd32440, 16'd32440);
            4: set_trim(16'd0, 16'd40000);
            5: set_trim(16'd50000, 16'd0);
            default: begin
               set_trim(16'($urandom_range(0, 30000)), 16'($urandom_range(0, 30000)));
            end
         endcase
         gapless = (p % 3 == 2);
         count = 0;
         while (count < 40) begin
            v = $urandom_range(0, 1);
            size = ($urandom_range(0, 7) == 0) ? $urandom_range(9, 48)
                                                : $urandom_range(1, 8);
            for (int i = 0; i < size; i++) begin
               // Occasional stray sample into the other view, left unfinished.
               if ($urandom_range(0, 9) == 0) queue_sample(!v, pick_value(), 1'b0);
               queue_sample(v, pick_value(), i == size - 1);
            end
            count += size;
         end
         wait_idle();
      end

      if (error_count == 0 && expected_stats.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("*** FAILED ***");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #100000000;
      $display("*** FAILED ***");
      $finish;
   end

endmodule
